>>> rtl/fqp_pkg.sv
package fqp_pkg;

  localparam logic [7:0] NL_BYTE = 8'd10;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_LO = 8'h74;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 8;
  localparam int OFF_W = 7;
  localparam int PART_W = 3;
  localparam int WIDX_W = 2;
  localparam int WORD_W = 64;
  localparam int CODE_W = 2;
  localparam int CODES_PER_WORD = WORD_W / CODE_W;
  localparam int CIDX_W = $clog2(CODES_PER_WORD);
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] div;
    logic             ovf;
  } job_t;

  function automatic logic [CODE_W-1:0] code_of(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] c;
    c = CODE_A;
    case (b)
      CH_C_UP, CH_C_LO: c = CODE_C;
      CH_G_UP, CH_G_LO: c = CODE_G;
      CH_T_UP, CH_T_LO: c = CODE_T;
      default:          c = CODE_A;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/fqp_byte_if.sv
interface fqp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [fqp_pkg::BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

>>> rtl/fqp_word_if.sv
interface fqp_word_if;
  logic                       valid;
  logic                       ready;
  logic [fqp_pkg::PART_W-1:0] part;
  logic [fqp_pkg::WIDX_W-1:0] word_index;
  logic [fqp_pkg::WORD_W-1:0] packed_word;
  logic [fqp_pkg::LEN_W-1:0]  part_length;
  logic [fqp_pkg::OFF_W-1:0]  part_offset;
  logic                       truncated;
  logic                       last;

  modport source (output valid, output part, output word_index, output packed_word,
                  output part_length, output part_offset, output truncated,
                  output last, input ready);
  modport sink (input valid, input part, input word_index, input packed_word,
                input part_length, input part_offset, input truncated,
                input last, output ready);
endinterface

>>> rtl/fqp_store.sv
module fqp_store #(
  parameter int AW = 7
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW:0]                waddr,
  input  logic [fqp_pkg::CODE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW:0]                raddr,
  output logic [fqp_pkg::CODE_W-1:0] rdata
);

  localparam int DEPTH = 2 << AW;

  logic [fqp_pkg::CODE_W-1:0] mem_r [DEPTH];
  logic [fqp_pkg::CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/fqp_jobq.sv
module fqp_jobq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  fqp_pkg::job_t                  push_job,
  input  logic                           pop,
  output fqp_pkg::job_t                  head,
  output logic [fqp_pkg::JOBQ_CNT_W-1:0] count
);

  fqp_pkg::job_t                  slot_r [fqp_pkg::JOBQ_DEPTH];
  logic                           wr_ptr_r;
  logic                           rd_ptr_r;
  logic [fqp_pkg::JOBQ_CNT_W-1:0] cnt_r;
  logic [fqp_pkg::JOBQ_CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

>>> rtl/fqp_front.sv
module fqp_front #(
  parameter int MAX_LEN  = 128,
  parameter int SEGMENTS = 4,
  parameter int AW       = 7,
  parameter int SEG_W    = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fqp_byte_if.sink                       in_b,
  input  logic [fqp_pkg::JOBQ_CNT_W-1:0] q_count,
  output logic                           we,
  output logic [AW:0]                    waddr,
  output logic [fqp_pkg::CODE_W-1:0]     wdata,
  output logic                           push,
  output fqp_pkg::job_t                  push_job
);

  typedef enum logic [1:0] {PH_HEAD, PH_SEQ, PH_PLUS, PH_QUAL} phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [fqp_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [fqp_pkg::LEN_W-1:0]  quo_r, quo_nxt;
  logic [SEG_W-1:0]           rem_r, rem_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       bank_r, bank_nxt;
  logic                       accept;

  assign in_b.ready = (q_count != fqp_pkg::JOBQ_CNT_W'(fqp_pkg::JOBQ_DEPTH));
  assign accept     = in_b.valid && in_b.ready;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    ovf_nxt   = ovf_r;
    bank_nxt  = bank_r;
    we        = 1'b0;
    push      = 1'b0;
    if (accept) begin
      if (in_b.text_byte != fqp_pkg::NL_BYTE) begin
        if (phase_r == PH_SEQ) begin
          if (len_r < fqp_pkg::LEN_W'(MAX_LEN)) begin
            we      = 1'b1;
            len_nxt = len_r + 1'b1;
            if (rem_r == SEG_W'(SEGMENTS - 1)) begin
              rem_nxt = '0;
              quo_nxt = quo_r + 1'b1;
            end else begin
              rem_nxt = rem_r + 1'b1;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end else if (phase_r != PH_QUAL) begin
        phase_nxt = phase_t'(phase_r + 2'd1);
      end else begin
        push      = 1'b1;
        bank_nxt  = ~bank_r;
        phase_nxt = PH_HEAD;
        len_nxt   = '0;
        quo_nxt   = '0;
        rem_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      len_r   <= '0;
      quo_r   <= '0;
      rem_r   <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      quo_r   <= quo_nxt;
      rem_r   <= rem_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
    end
  end

  assign waddr         = {bank_r, len_r[AW-1:0]};
  assign wdata         = fqp_pkg::code_of(in_b.text_byte);
  assign push_job.bank = bank_r;
  assign push_job.len  = len_r;
  assign push_job.div  = quo_r;
  assign push_job.ovf  = ovf_r;

endmodule

>>> rtl/fqp_back.sv
module fqp_back #(
  parameter int SEGMENTS = 4,
  parameter int AW       = 7,
  parameter int SEG_W    = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fqp_pkg::JOBQ_CNT_W-1:0] q_count,
  input  fqp_pkg::job_t                  head,
  output logic                           pop,
  output logic                           re,
  output logic [AW:0]                    raddr,
  input  logic [fqp_pkg::CODE_W-1:0]     rdata,
  fqp_word_if.source                     out_w
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT, S_EMIT} state_t;

  state_t                      state_r, state_nxt;
  logic [SEG_W-1:0]            part_r, part_nxt;
  logic [fqp_pkg::LEN_W-1:0]   off_r, off_nxt;
  logic [fqp_pkg::LEN_W-1:0]   plen_r, plen_nxt;
  logic [fqp_pkg::LEN_W-1:0]   idx_r, idx_nxt;
  logic [fqp_pkg::WIDX_W-1:0]  widx_r, widx_nxt;
  logic [fqp_pkg::WORD_W-1:0]  acc_r, acc_nxt;
  logic                        pend_r;
  logic [fqp_pkg::CIDX_W-1:0]  pend_idx_r;
  logic                        ov_r, ov_nxt;
  logic [fqp_pkg::PART_W-1:0]  o_part_r, o_part_nxt;
  logic [fqp_pkg::WIDX_W-1:0]  o_widx_r, o_widx_nxt;
  logic [fqp_pkg::WORD_W-1:0]  o_word_r, o_word_nxt;
  logic [fqp_pkg::LEN_W-1:0]   o_len_r, o_len_nxt;
  logic [fqp_pkg::OFF_W-1:0]   o_off_r, o_off_nxt;
  logic                        o_trunc_r, o_trunc_nxt;
  logic                        o_last_r, o_last_nxt;
  logic [fqp_pkg::LEN_W-1:0]   pos;
  logic [SEG_W-1:0]            next_part;
  logic [fqp_pkg::LEN_W-1:0]   next_off;
  logic                        more_words;
  logic                        final_part;
  logic                        out_free;

  assign pos        = off_r + plen_r - fqp_pkg::LEN_W'(1) - idx_r;
  assign raddr      = {head.bank, pos[AW-1:0]};
  assign next_part  = part_r + 1'b1;
  assign next_off   = (part_r == '0) ? '0 : off_r + head.div;
  assign more_words = (idx_r != plen_r);
  assign final_part = (part_r == SEG_W'(SEGMENTS));
  assign out_free   = !ov_r || out_w.ready;

  always_comb begin
    state_nxt   = state_r;
    part_nxt    = part_r;
    off_nxt     = off_r;
    plen_nxt    = plen_r;
    idx_nxt     = idx_r;
    widx_nxt    = widx_r;
    acc_nxt     = acc_r;
    ov_nxt      = ov_r && !out_w.ready;
    o_part_nxt  = o_part_r;
    o_widx_nxt  = o_widx_r;
    o_word_nxt  = o_word_r;
    o_len_nxt   = o_len_r;
    o_off_nxt   = o_off_r;
    o_trunc_nxt = o_trunc_r;
    o_last_nxt  = o_last_r;
    re          = 1'b0;
    pop         = 1'b0;
    if (pend_r) begin
      acc_nxt = acc_r | (fqp_pkg::WORD_W'(rdata) << {pend_idx_r, 1'b0});
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_count != '0) begin
          part_nxt  = '0;
          off_nxt   = '0;
          plen_nxt  = head.len;
          idx_nxt   = '0;
          widx_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (plen_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          re      = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (idx_r == plen_r - 1'b1 ||
              idx_r[fqp_pkg::CIDX_W-1:0] == fqp_pkg::CIDX_W'(fqp_pkg::CODES_PER_WORD - 1)) begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_part_nxt  = fqp_pkg::PART_W'(part_r);
          o_widx_nxt  = widx_r;
          o_word_nxt  = acc_r;
          o_len_nxt   = plen_r;
          o_off_nxt   = off_r[fqp_pkg::OFF_W-1:0];
          o_trunc_nxt = head.ovf;
          o_last_nxt  = !more_words && final_part;
          acc_nxt     = '0;
          if (more_words) begin
            widx_nxt  = widx_r + 1'b1;
            state_nxt = S_READ;
          end else if (!final_part) begin
            part_nxt  = next_part;
            off_nxt   = next_off;
            plen_nxt  = (next_part == SEG_W'(SEGMENTS)) ? head.len - next_off : head.div;
            idx_nxt   = '0;
            widx_nxt  = '0;
            state_nxt = S_READ;
          end else begin
            pop       = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= re;
      ov_r    <= ov_nxt;
    end
    part_r     <= part_nxt;
    off_r      <= off_nxt;
    plen_r     <= plen_nxt;
    idx_r      <= idx_nxt;
    widx_r     <= widx_nxt;
    acc_r      <= acc_nxt;
    pend_idx_r <= idx_r[fqp_pkg::CIDX_W-1:0];
    o_part_r   <= o_part_nxt;
    o_widx_r   <= o_widx_nxt;
    o_word_r   <= o_word_nxt;
    o_len_r    <= o_len_nxt;
    o_off_r    <= o_off_nxt;
    o_trunc_r  <= o_trunc_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_w.valid       = ov_r;
  assign out_w.part        = o_part_r;
  assign out_w.word_index  = o_widx_r;
  assign out_w.packed_word = o_word_r;
  assign out_w.part_length = o_len_r;
  assign out_w.part_offset = o_off_r;
  assign out_w.truncated   = o_trunc_r;
  assign out_w.last        = o_last_r;

endmodule

>>> rtl/fastq_read_parse_and_pack.sv
// Text bytes are taken one per cycle while fewer than two records wait for packing.
// Each record is packed part by part (the whole sequence and its sub-parts), reading its bases
// one at a time through the single base-store read port, with a store wait for each output word.
// After the record's last newline is accepted, the record is queued; once the packer is idle it
// reads the first word's bases, waits on the store, and emits the word when the output is free.
// Synchronous active-low reset clears the parser, record queue and packer, but not the store.
module fastq_read_parse_and_pack #(
  parameter int MAX_LEN  = 128,
  parameter int SEGMENTS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  fqp_byte_if.sink   in_b,
  fqp_word_if.source out_w
);

  localparam int AW    = $clog2(MAX_LEN);
  localparam int SEG_W = $clog2(SEGMENTS + 1);

  logic                           we;
  logic [AW:0]                    waddr;
  logic [fqp_pkg::CODE_W-1:0]     wdata;
  logic                           re;
  logic [AW:0]                    raddr;
  logic [fqp_pkg::CODE_W-1:0]     rdata;
  logic                           q_push;
  logic                           q_pop;
  fqp_pkg::job_t                  q_in;
  fqp_pkg::job_t                  q_head;
  logic [fqp_pkg::JOBQ_CNT_W-1:0] q_count;

  fqp_front #(
    .MAX_LEN (MAX_LEN),
    .SEGMENTS(SEGMENTS),
    .AW      (AW),
    .SEG_W   (SEG_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_b    (in_b),
    .q_count (q_count),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .push    (q_push),
    .push_job(q_in)
  );

  fqp_store #(
    .AW(AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  fqp_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(q_in),
    .pop     (q_pop),
    .head    (q_head),
    .count   (q_count)
  );

  fqp_back #(
    .SEGMENTS(SEGMENTS),
    .AW      (AW),
    .SEG_W   (SEG_W)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_count(q_count),
    .head   (q_head),
    .pop    (q_pop),
    .re     (re),
    .raddr  (raddr),
    .rdata  (rdata),
    .out_w  (out_w)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= fqp_pkg::JOBQ_CNT_W'(fqp_pkg::JOBQ_DEPTH))
    else $error("record queue over capacity");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_count != fqp_pkg::JOBQ_CNT_W'(fqp_pkg::JOBQ_DEPTH))
    else $error("record pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_count != '0)
    else $error("record popped from an empty queue");

  a_pop_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_w.valid && out_w.last)
    else $error("record finished without a final beat");

endmodule
